### rtl/bdsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsm_pkg
// Shared widths, register indexes and stage types of the 4x4 ARGB downsampler.
// ----------------------------------------------------------------------------
package bdsm_pkg;

   localparam int NUM_CH    = 4;
   localparam int CH_W      = 8;
   localparam int PART_W    = 10;
   localparam int SUM_W     = 12;
   localparam int PIXEL_W   = NUM_CH * CH_W;
   localparam int SUB_COL_W = 8;
   localparam int SUB_ROW_W = 10;
   localparam int CNT_W     = 14;
   localparam int ADDR_W    = 26;
   localparam int COLS_W    = 7;
   localparam int ROWS_W    = 9;
   localparam int CSR_W     = 26;
   localparam int CSR_IDX_W = 2;
   localparam int LINE_W    = NUM_CH * SUM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_BASE = 2'd2;

   localparam logic [ROWS_W-1:0] ROWS_CAP = 9'd256;

   typedef logic [NUM_CH-1:0][PART_W-1:0] partial_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0]  sums_type;

   // what the front stage hands to the line store stage for one block end
   typedef struct packed {
      partial_type       partial;
      logic              blk_end;
      logic              emit;
      logic              block_top;
      logic [ADDR_W-1:0] dest;
      logic              eoi;
   } front_info_type;

endpackage

### rtl/bdsm_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsm_line_store
// Synchronous line store of block-column sums, one write and one read port.
// ----------------------------------------------------------------------------
module bdsm_line_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  bdsm_pkg::sums_type          wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output bdsm_pkg::sums_type          rd_data
);

   bdsm_pkg::sums_type mem [DEPTH];
   bdsm_pkg::sums_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bdsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsm_front
// Subpixel counters, horizontal 4-subpixel sums and line store read issue.
// ----------------------------------------------------------------------------
module bdsm_front #(
   parameter int MAX_OUT_COLS = 64,
   parameter int AW           = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [bdsm_pkg::PIXEL_W-1:0]      subpixel,
   input  logic [bdsm_pkg::COLS_W-1:0]       out_cols,
   input  logic [bdsm_pkg::ROWS_W-1:0]       out_rows,
   input  logic [bdsm_pkg::ADDR_W-1:0]       out_base,
   output bdsm_pkg::front_info_type          info,
   output logic [AW-1:0]                     col_addr,
   output logic                              rd_en
);

   localparam int COLS_MAX  = (1 << bdsm_pkg::COLS_W) - 1;
   localparam int COLS_CAP  = (MAX_OUT_COLS < COLS_MAX) ? MAX_OUT_COLS : COLS_MAX;
   localparam int COL_LAST  = MAX_OUT_COLS - 1;
   localparam int BCOL_W    = bdsm_pkg::SUB_COL_W - 2;

   logic [bdsm_pkg::SUB_COL_W-1:0] sub_col_ff, sub_col_in;
   logic [bdsm_pkg::SUB_ROW_W-1:0] sub_row_ff, sub_row_in;
   logic [bdsm_pkg::CNT_W-1:0]     out_count_ff, out_count_in;
   bdsm_pkg::partial_type          row_partial_ff, row_partial_in;

   logic [bdsm_pkg::COLS_W-1:0]    eff_cols;
   logic [bdsm_pkg::ROWS_W-1:0]    eff_rows;
   logic [bdsm_pkg::COLS_W+1:0]    last_col;
   logic [bdsm_pkg::ROWS_W+1:0]    last_row;
   logic                           row_end;
   logic                           img_end;
   logic                           blk_end;
   logic                           emit;
   logic [BCOL_W-1:0]              bcol;
   bdsm_pkg::partial_type          sum_now;

   always_comb begin
      eff_cols = (out_cols == '0) ? bdsm_pkg::COLS_W'(1) : out_cols;
      if (32'(eff_cols) > COLS_CAP) begin
         eff_cols = bdsm_pkg::COLS_W'(COLS_CAP);
      end
      eff_rows = (out_rows == '0) ? bdsm_pkg::ROWS_W'(1) : out_rows;
      if (eff_rows > bdsm_pkg::ROWS_CAP) begin
         eff_rows = bdsm_pkg::ROWS_CAP;
      end
      last_col = {eff_cols, 2'b00} - (bdsm_pkg::COLS_W+2)'(1);
      last_row = {eff_rows, 2'b00} - (bdsm_pkg::ROWS_W+2)'(1);
      row_end  = (bdsm_pkg::COLS_W+2)'(sub_col_ff) >= last_col;
      img_end  = row_end && ((bdsm_pkg::ROWS_W+2)'(sub_row_ff) >= last_row);
      blk_end  = sub_col_ff[1:0] == 2'b11;
      emit     = blk_end && (sub_row_ff[1:0] == 2'b11);
      bcol     = sub_col_ff[bdsm_pkg::SUB_COL_W-1:2];
      col_addr = (32'(bcol) > COL_LAST) ? AW'(COL_LAST) : AW'(bcol);
      for (int ch = 0; ch < bdsm_pkg::NUM_CH; ch++) begin
         sum_now[ch] = row_partial_ff[ch] +
                       bdsm_pkg::PART_W'(subpixel[ch*bdsm_pkg::CH_W +: bdsm_pkg::CH_W]);
      end
   end

   assign rd_en = accept && blk_end && (sub_row_ff[1:0] != 2'b00);

   always_comb begin
      info.partial   = sum_now;
      info.blk_end   = blk_end;
      info.emit      = emit;
      info.block_top = sub_row_ff[1:0] == 2'b00;
      info.dest      = out_base + bdsm_pkg::ADDR_W'(out_count_ff);
      info.eoi       = img_end;
   end

   always_comb begin
      sub_col_in     = sub_col_ff;
      sub_row_in     = sub_row_ff;
      out_count_in   = out_count_ff;
      row_partial_in = row_partial_ff;
      if (accept) begin
         row_partial_in = (blk_end || row_end) ? '0 : sum_now;
         if (emit) begin
            out_count_in = out_count_ff + bdsm_pkg::CNT_W'(1);
         end
         if (row_end) begin
            sub_col_in = '0;
            if (img_end) begin
               sub_row_in   = '0;
               out_count_in = '0;
            end else begin
               sub_row_in = sub_row_ff + bdsm_pkg::SUB_ROW_W'(1);
            end
         end else begin
            sub_col_in = sub_col_ff + bdsm_pkg::SUB_COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff     <= '0;
         sub_row_ff     <= '0;
         out_count_ff   <= '0;
         row_partial_ff <= '0;
      end else begin
         sub_col_ff     <= sub_col_in;
         sub_row_ff     <= sub_row_in;
         out_count_ff   <= out_count_in;
         row_partial_ff <= row_partial_in;
      end
   end

endmodule

### rtl/box_downsample_4x4_argb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_4x4_argb_unit
// 4x4 box-filter downsampler for 32-bit ARGB subpixels with a column line store.
// ----------------------------------------------------------------------------
// Takes one subpixel per cycle unless stalled, in raster order over an image of
// 4*out_cols by 4*out_rows subpixels, and returns one averaged ARGB pixel per 4x4
// block with its destination address and an end-of-image flag. A pixel passes the
// block-end stage register and then the result register after the transfer of the
// last subpixel of its block. Block-column sums live in a single synchronous line
// store of MAX_OUT_COLS entries: a block end below the top row of its block reads
// its entry at transfer, one above the bottom row writes it back on the following
// cycle, and a block end comes at most once every four subpixels, so the one read
// and one write port carry the full rate. The input stalls only when a pixel is
// ready while the result register is still held by a stalled consumer.
module box_downsample_4x4_argb_unit #(
   parameter int MAX_OUT_COLS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bdsm_pkg::PIXEL_W-1:0]        req_subpixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bdsm_pkg::PIXEL_W-1:0]        rsp_pixel,
   output logic [bdsm_pkg::ADDR_W-1:0]         rsp_dest_address,
   output logic                                rsp_end_of_image,
   input  logic                                csr_write,
   input  logic [bdsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdsm_pkg::CSR_W-1:0]          csr_data
);

   localparam int AW = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;

   logic [bdsm_pkg::COLS_W-1:0] out_cols_ff, out_cols_in;
   logic [bdsm_pkg::ROWS_W-1:0] out_rows_ff, out_rows_in;
   logic [bdsm_pkg::ADDR_W-1:0] out_base_ff, out_base_in;

   logic                        accept;
   bdsm_pkg::front_info_type    front_info;
   logic [AW-1:0]               col_addr;
   logic                        rd_en;
   bdsm_pkg::sums_type          rd_data;

   logic                        s1_valid_ff, s1_valid_in;
   bdsm_pkg::front_info_type    s1_info_ff;
   logic [AW-1:0]               s1_addr_ff;
   logic                        s1_move;
   logic                        wr_en;
   bdsm_pkg::sums_type          sums;
   logic [bdsm_pkg::PIXEL_W-1:0] pixel;
   logic [bdsm_pkg::SUM_W:0]    rounded [bdsm_pkg::NUM_CH];

   logic                        out_valid_ff, out_valid_in;
   logic [bdsm_pkg::PIXEL_W-1:0] out_pixel_ff;
   logic [bdsm_pkg::ADDR_W-1:0] out_dest_ff;
   logic                        out_eoi_ff;
   logic                        wr_addr_ne;

   // configuration registers
   always_comb begin
      out_cols_in = out_cols_ff;
      out_rows_in = out_rows_ff;
      out_base_in = out_base_ff;
      if (csr_write) begin
         unique case (csr_index)
            bdsm_pkg::CSR_OUT_COLS: out_cols_in = csr_data[bdsm_pkg::COLS_W-1:0];
            bdsm_pkg::CSR_OUT_ROWS: out_rows_in = csr_data[bdsm_pkg::ROWS_W-1:0];
            bdsm_pkg::CSR_OUT_BASE: out_base_in = csr_data[bdsm_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cols_ff <= bdsm_pkg::COLS_W'(1);
         out_rows_ff <= bdsm_pkg::ROWS_W'(1);
         out_base_ff <= '0;
      end else begin
         out_cols_ff <= out_cols_in;
         out_rows_ff <= out_rows_in;
         out_base_ff <= out_base_in;
      end
   end

   // handshake
   assign s1_move   = s1_valid_ff && !(s1_info_ff.emit && out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   bdsm_front #(
      .MAX_OUT_COLS (MAX_OUT_COLS),
      .AW           (AW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .subpixel (req_subpixel),
      .out_cols (out_cols_ff),
      .out_rows (out_rows_ff),
      .out_base (out_base_ff),
      .info     (front_info),
      .col_addr (col_addr),
      .rd_en    (rd_en)
   );

   bdsm_line_store #(
      .DEPTH (MAX_OUT_COLS),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (sums),
      .rd_en   (rd_en),
      .rd_addr (col_addr),
      .rd_data (rd_data)
   );

   // block-end stage: add the stored column sum, write back or form the pixel
   always_comb begin
      for (int ch = 0; ch < bdsm_pkg::NUM_CH; ch++) begin
         sums[ch] = (s1_info_ff.block_top ? '0 : rd_data[ch]) +
                    bdsm_pkg::SUM_W'(s1_info_ff.partial[ch]);
         rounded[ch] = {1'b0, sums[ch]} + (bdsm_pkg::SUM_W+1)'(8);
         pixel[ch*bdsm_pkg::CH_W +: bdsm_pkg::CH_W] = rounded[ch][bdsm_pkg::CH_W+3:4];
      end
   end

   // entries of consecutive block ends are at least four transfers apart
   assign wr_en = s1_move && !s1_info_ff.emit;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept && front_info.blk_end) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && front_info.blk_end) begin
         s1_info_ff <= front_info;
         s1_addr_ff <= col_addr;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_move && s1_info_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_info_ff.emit) begin
         out_pixel_ff <= pixel;
         out_dest_ff  <= s1_info_ff.dest;
         out_eoi_ff   <= s1_info_ff.eoi;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel        = out_pixel_ff;
   assign rsp_dest_address = out_dest_ff;
   assign rsp_end_of_image = out_eoi_ff;

   assign wr_addr_ne = s1_addr_ff != col_addr;

   // checks
   a_no_same_entry_rw: assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr_ne)
      else $error("line store read and write hit the same entry");

   a_stage_holds_block_end: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_info_ff.blk_end)
      else $error("block-end stage holds a non block-end transfer");

   a_no_read_while_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |-> !rd_en)
      else $error("line store read while pending read data is held");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !(s1_move && s1_info_ff.emit))
      else $error("held result overwritten");

endmodule
